// File: design/tkc_pkg.sv
// Package for the C preprocessor token classifier.
// Holds token class codes, character constants and the state and result types.
// Has no dependencies; every module of the block imports it.
`default_nettype none

package tkc_pkg;

    // Token classes, in the encoding seen on the result port.
    typedef enum logic [3:0] {
        CL_SPACE    = 4'd0,
        CL_LINECOM  = 4'd1,
        CL_BLOCKCOM = 4'd2,
        CL_IDENT    = 4'd3,
        CL_NUMBER   = 4'd4,
        CL_STRING   = 4'd5,
        CL_HASH     = 4'd6,
        CL_DHASH    = 4'd7,
        CL_COMMA    = 4'd8,
        CL_OPEN     = 4'd9,
        CL_CLOSE    = 4'd10,
        CL_GREATER  = 4'd11,
        CL_LESS     = 4'd12,
        CL_OTHER    = 4'd13
    } tkc_class_t;

    // Number scanning phases.
    localparam logic [1:0] NUM_IDLE   = 2'd0;
    localparam logic [1:0] NUM_ZERO   = 2'd1;
    localparam logic [1:0] NUM_DIGITS = 2'd2;

    // Characters with a meaning to the scanner.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [31:0] LINE_FIRST = 32'd1;
    localparam logic [31:0] LINE_MAX   = 32'hFFFF_FFFF;

    // Scanner state carried from byte to byte.
    typedef struct packed {
        tkc_class_t  cls;
        logic        escape;
        logic [1:0]  num_phase;
        logic        hex_ok;
        logic        com_opened;
        logic        com_closing;
        logic [31:0] line;
    } tkc_state_t;

    // Classification of one byte.
    typedef struct packed {
        logic [7:0]  data;
        logic [3:0]  cls;
        logic        start;
        logic [31:0] line;
    } tkc_byte_res_t;

    // One result transaction as held in the output buffer.
    typedef struct packed {
        tkc_byte_res_t res;
        logic          text_end;
        logic          last;
    } tkc_out_t;

    localparam tkc_state_t STATE_RESET = '{
        cls: CL_SPACE, escape: 1'b0, num_phase: NUM_IDLE, hex_ok: 1'b0,
        com_opened: 1'b0, com_closing: 1'b0, line: LINE_FIRST
    };

endpackage

`default_nettype wire

// File: design/tkc_classify.sv
// Combinational classification of one byte against an optional lookahead byte.
// Depends on tkc_pkg for the state, result types and character codes.
`default_nettype none

module tkc_classify
    import tkc_pkg::*;
(
    input  wire tkc_state_t  st_in,
    input  wire logic [7:0]  cur_byte,
    input  wire logic        has_next,
    input  wire logic [7:0]  next_byte,
    output tkc_state_t       st_out,
    output tkc_byte_res_t    res
);

    logic c_digit;
    logic c_hex;
    logic c_alpha;
    logic c_space;
    logic la_slash;
    logic la_star;
    logic la_hash;
    logic fresh;
    tkc_class_t cls;
    logic start;

    // Character tests.
    assign c_digit = (cur_byte >= 8'h30) && (cur_byte <= 8'h39);
    assign c_alpha = ((cur_byte >= 8'h61) && (cur_byte <= 8'h7A)) ||
                     ((cur_byte >= 8'h41) && (cur_byte <= 8'h5A)) || (cur_byte == 8'h5F);
    assign c_hex   = c_digit || ((cur_byte >= 8'h61) && (cur_byte <= 8'h66)) ||
                     ((cur_byte >= 8'h41) && (cur_byte <= 8'h46));
    assign c_space = (cur_byte == CH_SPACE) || (cur_byte == CH_TAB) ||
                     (cur_byte == CH_LF) || (cur_byte == CH_CR);
    assign la_slash = has_next && (next_byte == CH_SLASH);
    assign la_star  = has_next && (next_byte == CH_STAR);
    assign la_hash  = has_next && (next_byte == CH_HASH);

    // Continue the open token, or fall through to start a new one.
    always_comb begin
        st_out = st_in;
        fresh  = 1'b0;
        cls    = CL_SPACE;
        start  = 1'b0;
        case (st_in.cls)
            CL_LINECOM: begin
                if (cur_byte == CH_LF) begin
                    st_out.cls = CL_SPACE;
                    fresh = 1'b1;
                end else begin
                    cls = CL_LINECOM;
                end
            end
            CL_BLOCKCOM: begin
                cls = CL_BLOCKCOM;
                if (st_in.com_opened) begin
                    st_out.com_opened = 1'b0;
                end else if (st_in.com_closing) begin
                    st_out.com_closing = 1'b0;
                    st_out.cls = CL_SPACE;
                end else if (cur_byte == CH_STAR && la_slash) begin
                    st_out.com_closing = 1'b1;
                end
            end
            CL_IDENT: begin
                if (c_alpha || c_digit) begin
                    cls = CL_IDENT;
                end else begin
                    st_out.cls = CL_SPACE;
                    fresh = 1'b1;
                end
            end
            CL_NUMBER: begin
                if (st_in.num_phase == NUM_ZERO && (cur_byte == CH_X || cur_byte == CH_B)) begin
                    cls = CL_NUMBER;
                    st_out.hex_ok = (cur_byte == CH_X);
                    st_out.num_phase = NUM_DIGITS;
                end else if (c_digit || (st_in.hex_ok && c_hex)) begin
                    cls = CL_NUMBER;
                    st_out.num_phase = NUM_DIGITS;
                end else begin
                    st_out.cls = CL_SPACE;
                    st_out.num_phase = NUM_IDLE;
                    st_out.hex_ok = 1'b0;
                    fresh = 1'b1;
                end
            end
            CL_STRING: begin
                if (cur_byte == CH_BSLASH) begin
                    st_out.escape = !st_in.escape;
                    cls = CL_STRING;
                end else if (!st_in.escape && cur_byte == CH_QUOTE) begin
                    cls = CL_STRING;
                    st_out.cls = CL_SPACE;
                end else if (!st_in.escape && cur_byte == CH_LF) begin
                    st_out.cls = CL_SPACE;
                    fresh = 1'b1;
                end else begin
                    st_out.escape = 1'b0;
                    cls = CL_STRING;
                end
            end
            CL_DHASH: begin
                cls = CL_DHASH;
                st_out.cls = CL_SPACE;
            end
            default: begin
                st_out.cls = CL_SPACE;
                fresh = 1'b1;
            end
        endcase

        // Start of a new token.
        if (fresh) begin
            start = 1'b1;
            if (cur_byte == CH_SLASH && la_slash) begin
                cls = CL_LINECOM;
                st_out.cls = CL_LINECOM;
            end else if (cur_byte == CH_SLASH && la_star) begin
                cls = CL_BLOCKCOM;
                st_out.cls = CL_BLOCKCOM;
                st_out.com_opened = 1'b1;
                st_out.com_closing = 1'b0;
            end else if (c_space) begin
                cls = CL_SPACE;
                start = 1'b0;
            end else if (c_alpha) begin
                cls = CL_IDENT;
                st_out.cls = CL_IDENT;
            end else if (c_digit) begin
                cls = CL_NUMBER;
                st_out.cls = CL_NUMBER;
                st_out.num_phase = (cur_byte == CH_ZERO) ? NUM_ZERO : NUM_DIGITS;
                st_out.hex_ok = 1'b0;
            end else if (cur_byte == CH_QUOTE) begin
                cls = CL_STRING;
                st_out.cls = CL_STRING;
                st_out.escape = 1'b0;
            end else if (cur_byte == CH_HASH && la_hash) begin
                cls = CL_DHASH;
                st_out.cls = CL_DHASH;
            end else if (cur_byte == CH_HASH) begin
                cls = CL_HASH;
            end else if (cur_byte == CH_COMMA) begin
                cls = CL_COMMA;
            end else if (cur_byte == CH_LPAREN) begin
                cls = CL_OPEN;
            end else if (cur_byte == CH_RPAREN) begin
                cls = CL_CLOSE;
            end else if (cur_byte == CH_GT) begin
                cls = CL_GREATER;
            end else if (cur_byte == CH_LT) begin
                cls = CL_LESS;
            end else begin
                cls = CL_OTHER;
            end
        end

        // A newline lies on the line it ends; the counter saturates.
        if (cur_byte == CH_LF && st_in.line != LINE_MAX) begin
            st_out.line = st_in.line + LINE_FIRST;
        end
    end

    assign res.data  = cur_byte;
    assign res.cls   = cls;
    assign res.start = start;
    assign res.line  = st_in.line;

endmodule

`default_nettype wire

// File: design/tkc_out_buf.sv
// Two-entry result buffer for the tkc_pkg result type: takes up to two results
// per input transaction and presents them one per cycle while pop_ready is high.
`default_nettype none

module tkc_out_buf
    import tkc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire logic     push_two,
    input  wire tkc_out_t first_in,
    input  wire tkc_out_t second_in,
    output logic          room,
    input  wire logic     pop_ready,
    output logic          head_valid,
    output tkc_out_t      head
);

    logic     v0_reg, v0_next;
    logic     v1_reg, v1_next;
    tkc_out_t d0_reg, d0_next;
    tkc_out_t d1_reg, d1_next;
    logic     pop;

    assign pop        = v0_reg && pop_ready;
    // Entry one is only ever filled behind entry zero, so this leaves two free slots.
    assign room       = !v1_reg && (!v0_reg || pop_ready);
    assign head_valid = v0_reg;
    assign head       = d0_reg;

    // Load on a push, otherwise shift on a pop.
    always_comb begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (push) begin
            v0_next = 1'b1;
            v1_next = push_two;
            d0_next = first_in;
            d1_next = second_in;
        end else if (pop) begin
            v0_next = v1_reg;
            v1_next = 1'b0;
            d0_next = d1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

endmodule

`default_nettype wire

// File: design/c_preprocessor_token_classifier.sv
// Latency: a byte's result is registered one transaction later (lookahead),
// or in the cycle after the transaction for a final byte, which flushes it.
// Throughput: one byte per cycle while m_tready is high; a final byte with a held
// byte gives two results, and input waits while the second sits in entry one of the buffer.
// Reset (aresetn low, synchronous) clears the lookahead, the scanner state
// and the output buffer; the line counter restarts at 1.
`default_nettype none

module c_preprocessor_token_classifier
    import tkc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] out_byte, [39:8] line_number
    output logic [7:0]       m_tuser,   // [3:0] token_class, [4] token_start,
                                        // [5] text_end, [7:6] zero
    output logic             m_tlast    // last_of_run
);

    tkc_state_t    st_reg, st_next;
    logic [7:0]    held_byte_reg, held_byte_next;
    logic          held_valid_reg, held_valid_next;
    tkc_state_t    st_a;
    tkc_state_t    st_b_in;
    tkc_state_t    st_b;
    tkc_byte_res_t res_a;
    tkc_byte_res_t res_b;
    tkc_out_t      first_out;
    tkc_out_t      second_out;
    tkc_out_t      head;
    logic          accept;

    assign accept = s_tvalid && s_tready;

    // Held byte classified with the incoming byte as lookahead.
    tkc_classify u_cls_held (
        .st_in     (st_reg),
        .cur_byte  (held_byte_reg),
        .has_next  (1'b1),
        .next_byte (s_tdata),
        .st_out    (st_a),
        .res       (res_a)
    );

    // Final byte classified with no lookahead.
    assign st_b_in = held_valid_reg ? st_a : st_reg;

    tkc_classify u_cls_final (
        .st_in     (st_b_in),
        .cur_byte  (s_tdata),
        .has_next  (1'b0),
        .next_byte (s_tdata),
        .st_out    (st_b),
        .res       (res_b)
    );

    // Order the results of this transaction, held byte first.
    always_comb begin
        if (held_valid_reg) begin
            first_out = '{res: res_a, text_end: 1'b0, last: !s_tlast};
        end else begin
            first_out = '{res: res_b, text_end: 1'b1, last: 1'b1};
        end
        second_out = '{res: res_b, text_end: 1'b1, last: 1'b1};
    end

    tkc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept && (held_valid_reg || s_tlast)),
        .push_two   (held_valid_reg && s_tlast),
        .first_in   (first_out),
        .second_in  (second_out),
        .room       (s_tready),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head       (head)
    );

    // Scanner state and lookahead update; a final byte returns all to reset.
    always_comb begin
        st_next         = st_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (accept) begin
            if (s_tlast) begin
                st_next         = STATE_RESET;
                held_byte_next  = 8'd0;
                held_valid_next = 1'b0;
            end else begin
                st_next         = st_b_in;
                held_byte_next  = s_tdata;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= STATE_RESET;
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
        end else begin
            st_reg         <= st_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // Result port packing.
    assign m_tdata = {head.res.line, head.res.data};
    assign m_tuser = {2'b00, head.text_end, head.res.start, head.res.cls};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// File: sim/tb_c_preprocessor_token_classifier.sv
// Self-checking testbench for the C preprocessor token classifier.
// Drives random and directed source texts and checks every tagged byte against
// a predictor of the scanner. Depends on tkc_pkg and the classifier top level.

module tb_c_preprocessor_token_classifier;
    import tkc_pkg::*;

    localparam int RANDOM_BYTES = 500;
    localparam int TAIL_ITEMS   = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // One source byte waiting to be sent.
    typedef struct {
        logic [7:0] data;
        logic       fin;
    } text_item_t;

    // Expected tagging of one source byte.
    typedef struct {
        logic [7:0]  data;
        tkc_class_t  cls;
        logic        start;
        logic [31:0] line;
        logic        text_end;
        logic        last;
    } byte_tag_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] text_byte
    logic        s_tlast;   // final_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [7:0] out_byte, [39:8] line_number
    logic [7:0]  m_tuser;   // [3:0] token_class, [4] token_start, [5] text_end, [7:6] zero
    logic        m_tlast;   // last_of_run

    text_item_t  text_items_q[$];
    byte_tag_t   byte_tags_q[$];
    logic [7:0]  text_buf[$];

    // Predictor copy of the scanner state.
    logic [7:0]  held_byte;
    logic        held_valid;
    tkc_class_t  scan_cls;
    logic        scan_escape;
    logic [1:0]  scan_num_phase;
    logic        scan_hex_ok;
    logic        scan_com_opened;
    logic        scan_com_closing;
    logic [31:0] scan_line;

    int  error_count;
    int  bytes_accepted;
    int  texts_built;
    int  tags_checked;
    int  cycle_count;
    bit  in_taken;
    int  src_gap;
    int  src_run;
    int  snk_stall;
    int  snk_run;

    c_preprocessor_token_classifier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Returns the scanner to its state at the start of a text.
    task automatic clear_scanner();
        held_byte        = 8'h00;
        held_valid       = 1'b0;
        scan_cls         = CL_SPACE;
        scan_escape      = 1'b0;
        scan_num_phase   = NUM_IDLE;
        scan_hex_ok      = 1'b0;
        scan_com_opened  = 1'b0;
        scan_com_closing = 1'b0;
        scan_line        = LINE_FIRST;
    endtask

    // Tags byte c, seeing nx as the next byte when has_nx is set.
    task automatic tag_byte(input logic [7:0] c, input bit has_nx, input logic [7:0] nx,
                            input bit text_end, input bit last);
        bit         fresh;
        tkc_class_t cls;
        logic       start;
        byte_tag_t  tag;
        fresh = 1'b0;
        cls   = CL_SPACE;
        start = 1'b0;

        // Continue the token or comment in progress.
        case (scan_cls)
            CL_LINECOM: begin
                if (c == CH_LF) begin
                    scan_cls = CL_SPACE;
                    fresh = 1'b1;
                end else begin
                    cls = CL_LINECOM;
                end
            end
            CL_BLOCKCOM: begin
                cls = CL_BLOCKCOM;
                if (scan_com_opened) begin
                    scan_com_opened = 1'b0;
                end else if (scan_com_closing) begin
                    scan_com_closing = 1'b0;
                    scan_cls = CL_SPACE;
                end else if (c == CH_STAR && has_nx && nx == CH_SLASH) begin
                    scan_com_closing = 1'b1;
                end
            end
            CL_IDENT: begin
                if (is_word_start(c) || is_digit(c)) begin
                    cls = CL_IDENT;
                end else begin
                    scan_cls = CL_SPACE;
                    fresh = 1'b1;
                end
            end
            CL_NUMBER: begin
                if (scan_num_phase == NUM_ZERO && (c == CH_X || c == CH_B)) begin
                    cls = CL_NUMBER;
                    scan_hex_ok = (c == CH_X);
                    scan_num_phase = NUM_DIGITS;
                end else if (is_digit(c) || (scan_hex_ok && is_hex(c))) begin
                    cls = CL_NUMBER;
                    scan_num_phase = NUM_DIGITS;
                end else begin
                    scan_cls = CL_SPACE;
                    scan_num_phase = NUM_IDLE;
                    scan_hex_ok = 1'b0;
                    fresh = 1'b1;
                end
            end
            CL_STRING: begin
                if (c == CH_BSLASH) begin
                    scan_escape = !scan_escape;
                    cls = CL_STRING;
                end else if (!scan_escape && c == CH_QUOTE) begin
                    cls = CL_STRING;
                    scan_cls = CL_SPACE;
                end else if (!scan_escape && c == CH_LF) begin
                    scan_cls = CL_SPACE;
                    fresh = 1'b1;
                end else begin
                    scan_escape = 1'b0;
                    cls = CL_STRING;
                end
            end
            CL_DHASH: begin
                cls = CL_DHASH;
                scan_cls = CL_SPACE;
            end
            default: begin
                scan_cls = CL_SPACE;
                fresh = 1'b1;
            end
        endcase

        // Start a new token; the lookahead decides comments and double hash.
        if (fresh) begin
            start = 1'b1;
            if (c == CH_SLASH && has_nx && nx == CH_SLASH) begin
                cls = CL_LINECOM;
                scan_cls = CL_LINECOM;
            end else if (c == CH_SLASH && has_nx && nx == CH_STAR) begin
                cls = CL_BLOCKCOM;
                scan_cls = CL_BLOCKCOM;
                scan_com_opened = 1'b1;
                scan_com_closing = 1'b0;
            end else if (is_ws(c)) begin
                cls = CL_SPACE;
                start = 1'b0;
            end else if (is_word_start(c)) begin
                cls = CL_IDENT;
                scan_cls = CL_IDENT;
            end else if (is_digit(c)) begin
                cls = CL_NUMBER;
                scan_cls = CL_NUMBER;
                scan_num_phase = (c == CH_ZERO) ? NUM_ZERO : NUM_DIGITS;
                scan_hex_ok = 1'b0;
            end else if (c == CH_QUOTE) begin
                cls = CL_STRING;
                scan_cls = CL_STRING;
                scan_escape = 1'b0;
            end else if (c == CH_HASH && has_nx && nx == CH_HASH) begin
                cls = CL_DHASH;
                scan_cls = CL_DHASH;
            end else if (c == CH_HASH) begin
                cls = CL_HASH;
            end else if (c == CH_COMMA) begin
                cls = CL_COMMA;
            end else if (c == CH_LPAREN) begin
                cls = CL_OPEN;
            end else if (c == CH_RPAREN) begin
                cls = CL_CLOSE;
            end else if (c == CH_GT) begin
                cls = CL_GREATER;
            end else if (c == CH_LT) begin
                cls = CL_LESS;
            end else begin
                cls = CL_OTHER;
            end
        end

        tag.data     = c;
        tag.cls      = cls;
        tag.start    = start;
        tag.line     = scan_line;
        tag.text_end = text_end;
        tag.last     = last;
        byte_tags_q.push_back(tag);

        // A newline lies on the line it ends; the counter saturates.
        if (c == CH_LF && scan_line != LINE_MAX)
            scan_line = scan_line + 1;
    endtask

    // Works out the results of one accepted source byte.
    task automatic predict_text_byte(input logic [7:0] b, input logic fin);
        if (held_valid)
            tag_byte(held_byte, 1'b1, b, 1'b0, !fin);
        if (fin) begin
            tag_byte(b, 1'b0, 8'h00, 1'b1, 1'b1);
            clear_scanner();
        end else begin
            held_byte  = b;
            held_valid = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Text building helpers.
    task automatic put_ch(input logic [7:0] c);
        text_buf.push_back(c);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_ch(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Moves the text under construction to the send queue, final byte marked.
    task automatic flush_text();
        text_item_t item;
        for (int i = 0; i < text_buf.size(); i++) begin
            item.data = text_buf[i];
            item.fin  = (i == text_buf.size() - 1);
            text_items_q.push_back(item);
        end
        text_buf.delete();
        texts_built++;
    endtask

    // Appends one random token-like fragment to the current text.
    task automatic add_fragment();
        int    kind;
        int    n;
        string alnum;
        string hexd;
        alnum = "abcxyzXB_019";
        hexd  = "0123456789abcdefABCFgx";
        kind  = $urandom_range(0, 15);
        n     = $urandom_range(1, 4);
        case (kind)
            0: begin
                put_ch(pick_ch("abxzQ_B"));
                repeat ($urandom_range(0, 5)) put_ch(pick_ch(alnum));
            end
            1: repeat (n) put_ch(pick_ch("0123456789"));
            2: begin
                put_str("0x");
                repeat (n) put_ch(pick_ch(hexd));
            end
            3: begin
                put_str("0b");
                repeat (n) put_ch(pick_ch("0110b2"));
            end
            4: begin
                put_ch(CH_QUOTE);
                repeat ($urandom_range(0, 6)) put_ch(pick_ch("ab \\\\\"n#/"));
                case ($urandom_range(0, 3))
                    0, 1: put_ch(CH_QUOTE);
                    2: put_ch(CH_LF);
                    default: ;
                endcase
            end
            5: begin
                put_str("//");
                repeat ($urandom_range(0, 5)) put_ch(pick_ch("a */#\"\\"));
                if ($urandom_range(0, 3) != 0) put_ch(CH_LF);
            end
            6: begin
                put_str("/*");
                repeat ($urandom_range(0, 6)) put_ch(pick_ch("a*/\n #"));
                if ($urandom_range(0, 3) != 0) put_str("*/");
            end
            7: repeat (n) put_ch(CH_HASH);
            8: put_ch(pick_ch(",()<>"));
            9: repeat (n) put_ch(pick_ch(" \t\n"));
            10: repeat (n) put_ch(8'($urandom_range(0, 255)));
            11: put_ch(pick_ch("/*"));
            12, 13: put_ch(CH_SPACE);
            14: put_ch(CH_CR);
            default: put_ch(CH_ZERO);
        endcase
    endtask

    // Sender: presents queued bytes, with random gaps between transactions.
    always @(negedge aclk) begin : source_driver
        text_item_t item;
        if (aresetn === 1'b1 && (!s_tvalid || in_taken)) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap = src_gap - 1;
            end else if (text_items_q.size() > 0) begin
                item = text_items_q.pop_front();
                s_tdata  <= item.data;
                s_tlast  <= item.fin;
                s_tvalid <= 1'b1;
                if (src_run > 0) begin
                    src_run = src_run - 1;
                end else if (text_items_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 14);
                    src_run = $urandom_range(0, 40);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls in random bursts, none once the stimulus is nearly done.
    always @(negedge aclk) begin : sink_driver
        if (aresetn === 1'b1) begin
            if (snk_stall > 0) begin
                m_tready <= 1'b0;
                snk_stall = snk_stall - 1;
            end else begin
                m_tready <= 1'b1;
                if (snk_run > 0) begin
                    snk_run = snk_run - 1;
                end else if (text_items_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    snk_stall = $urandom_range(1, 14);
                    snk_run   = $urandom_range(0, 40);
                end
            end
        end
    end

    // Monitor: predicts on each input transaction and checks each result transaction.
    always @(posedge aclk) begin : monitor
        byte_tag_t want;
        in_taken = (aresetn === 1'b1) && s_tvalid && s_tready;
        if (in_taken) begin
            predict_text_byte(s_tdata, s_tlast);
            bytes_accepted++;
        end
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            if (byte_tags_q.size() == 0) begin
                report_mismatch("result with nothing expected, out_byte", m_tdata[7:0], 0);
            end else begin
                want = byte_tags_q.pop_front();
                tags_checked++;
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", m_tdata[7:0], want.data);
                if (m_tuser[3:0] !== want.cls)
                    report_mismatch("token_class", m_tuser[3:0], want.cls);
                if (m_tuser[4] !== want.start)
                    report_mismatch("token_start", m_tuser[4], want.start);
                if (m_tdata[39:8] !== want.line)
                    report_mismatch("line_number", m_tdata[39:8], want.line);
                if (m_tuser[5] !== want.text_end)
                    report_mismatch("text_end", m_tuser[5], want.text_end);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", m_tlast, want.last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, byte_tags_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int target;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        in_taken  = 1'b0;
        src_gap   = 0;
        src_run   = 0;
        snk_stall = 0;
        snk_run   = 0;
        error_count    = 0;
        bytes_accepted = 0;
        texts_built    = 0;
        tags_checked   = 0;
        cycle_count    = 0;
        clear_scanner();

        // Directed texts: an empty block comment, identifier, line comment.
        put_str("/**/_9//\n");
        flush_text();
        // Hash before a number, hex and binary prefixes, unterminated string.
        put_str("#0xF,0b1(\"\\\"");
        flush_text();
        // Zero byte, all-ones byte, brackets, double hash, final slash.
        put_ch(8'h00);
        put_ch(8'hFF);
        put_str(")<>##");
        put_ch(CH_CR);
        put_ch(CH_SLASH);
        flush_text();
        // A one-byte text: a final hash has no lookahead.
        put_ch(CH_HASH);
        flush_text();

        // Random texts built from token fragments, with some raw noise.
        while (text_items_q.size() < RANDOM_BYTES + 31) begin
            target = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
            while (text_buf.size() < target)
                add_fragment();
            flush_text();
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait until every byte is sent and every result has arrived.
        while (text_items_q.size() > 0 || s_tvalid || byte_tags_q.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d texts; checked %0d tagged bytes.",
                 bytes_accepted, texts_built, tags_checked);
        $display("Covered comments, numbers, strings, hashes, punctuation and noise bytes.");
        if (error_count == 0 && byte_tags_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     error_count, byte_tags_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
